// ===== hdl/gia_pkg.sv =====
// ----------------------------------------------------------------------------
// gia_pkg
// Shared op codes, status codes, operand slot and product slot names for the interval ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package gia_pkg;

  // Operation codes carried by each request
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_HULL  = 3'd4,
    OP_ISECT = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_INVALID = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  // Operand slots: first/second interval, lower/upper bound
  localparam logic [1:0] SLOT_A1 = 2'd0;
  localparam logic [1:0] SLOT_A2 = 2'd1;
  localparam logic [1:0] SLOT_B1 = 2'd2;
  localparam logic [1:0] SLOT_B2 = 2'd3;

  // End-point product slots
  localparam logic [1:0] P11 = 2'd0;
  localparam logic [1:0] P12 = 2'd1;
  localparam logic [1:0] P21 = 2'd2;
  localparam logic [1:0] P22 = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/generalized_interval_alu_top.sv =====
// ----------------------------------------------------------------------------
// generalized_interval_alu_top
// Generalized (Kaucher) interval ALU: add, subtract, multiply, divide, hull
// and intersect on signed fixed-point intervals that may be improper.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle while req_stall is low.
// The restoring divider, one quotient bit per stage for both quotients of a
// request, makes up most of the pipeline depth. A stalled result waits in the
// output register and one skid entry; the upstream side is stalled only
// when the skid entry is full. Bounds saturate, status 3 flags it.
`default_nettype none

module generalized_interval_alu_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [2:0]            op,
  input  logic [DATA_WIDTH-1:0] a_lo,
  input  logic [DATA_WIDTH-1:0] a_hi,
  input  logic [DATA_WIDTH-1:0] b_lo,
  input  logic [DATA_WIDTH-1:0] b_hi,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [DATA_WIDTH-1:0] r_lo,
  output logic [DATA_WIDTH-1:0] r_hi,
  output logic [1:0]            status
);
  import gia_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QW  = W + F + 1;
  localparam int SW1 = 3 + 2 + 2 * (W + 1) + 4 * W + 4;
  localparam int SW2 = 3 + 2 + 2 * (W + 1) + 2 * QW;

  logic               en;
  logic               d_v, c_v, m_v;
  op_t                d_op;
  logic [2:0]         c_op, m_op;
  status_t            d_st;
  logic [1:0]         c_st, m_st;
  logic [W:0]         d_slo, d_shi, m_slo, m_shi;
  logic [3:0][W-1:0]  d_mag, c_mag;
  logic [3:0]         d_sgn, c_sgn, m_sgn;
  logic [1:0][W-1:0]  d_num, d_den;
  logic [1:0]         d_qs;
  logic [SW1-1:0]     c_side_in, c_side;
  logic [SW2-1:0]     m_side_in, m_side;
  logic [1:0][W+F:0]  c_quo, m_quo;
  logic [3:0][2*W-F:0] prod;
  logic [W:0]         c_slo, c_shi;

  assign req_stall = !en;

  gia_decode #(.W(W)) u_decode (
    .clk(clk), .rst(rst), .en(en), .in_v(req_valid), .op(op),
    .a_lo(a_lo), .a_hi(a_hi), .b_lo(b_lo), .b_hi(b_hi),
    .d_v(d_v), .d_op(d_op), .d_st(d_st), .d_slo(d_slo), .d_shi(d_shi),
    .d_mag(d_mag), .d_sgn(d_sgn), .d_num(d_num), .d_den(d_den), .d_qs(d_qs)
  );

  // Carry the rest of the request alongside the divider
  assign c_side_in = {d_op, d_st, d_slo, d_shi, d_mag, d_sgn};

  gia_div_chain #(.W(W), .F(F), .SW(SW1)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_v(d_v), .side_in(c_side_in),
    .num(d_num), .den(d_den), .qs(d_qs),
    .out_v(c_v), .side_out(c_side), .quo(c_quo)
  );

  assign {c_op, c_st, c_slo, c_shi, c_mag, c_sgn} = c_side;
  assign m_side_in = {c_op, c_st, c_slo, c_shi, c_quo};

  gia_mul #(.W(W), .F(F), .SW(SW2)) u_mul (
    .clk(clk), .rst(rst), .en(en), .in_v(c_v), .side_in(m_side_in),
    .mag(c_mag), .sgn(c_sgn),
    .out_v(m_v), .side_out(m_side), .sgn_out(m_sgn), .prod(prod)
  );

  assign {m_op, m_st, m_slo, m_shi, m_quo} = m_side;

  gia_finish #(.W(W), .F(F)) u_finish (
    .clk(clk), .rst(rst), .in_v(m_v), .op(op_t'(m_op)), .st(status_t'(m_st)),
    .slo(m_slo), .shi(m_shi), .quo(m_quo), .prod(prod), .sgn(m_sgn),
    .res_stall(res_stall), .en(en),
    .res_valid(res_valid), .r_lo(r_lo), .r_hi(r_hi), .status(status)
  );

endmodule

`default_nettype wire

// ===== hdl/gia_decode.sv =====
// ----------------------------------------------------------------------------
// gia_decode
// Input stage: bound magnitudes and signs, add/subtract/hull/intersect,
// divisor checks and quotient operand selection.
// ----------------------------------------------------------------------------
`default_nettype none

module gia_decode #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [2:0]             op,
  input  logic [W-1:0]           a_lo,
  input  logic [W-1:0]           a_hi,
  input  logic [W-1:0]           b_lo,
  input  logic [W-1:0]           b_hi,
  output logic                   d_v,
  output gia_pkg::op_t           d_op,
  output gia_pkg::status_t       d_st,
  output logic [W:0]             d_slo,
  output logic [W:0]             d_shi,
  output logic [3:0][W-1:0]      d_mag,
  output logic [3:0]             d_sgn,
  output logic [1:0][W-1:0]      d_num,
  output logic [1:0][W-1:0]      d_den,
  output logic [1:0]             d_qs
);
  import gia_pkg::*;

  op_t                 opc;
  status_t             st;
  logic [3:0][W-1:0]   raw;
  logic [3:0][W-1:0]   mag;
  logic [3:0]          neg;
  logic                b1_pos, b2_pos, b_pos, b_neg;
  logic [1:0][1:0]     xi, yi;
  logic [1:0]          qs;
  logic signed [W:0]   ea1, ea2, eb1, eb2;
  logic [W:0]          slo, shi;
  logic                lt1, lt2;

  assign opc = op_t'(op);
  assign raw = {b_hi, b_lo, a_hi, a_lo};
  assign ea1 = $signed({a_lo[W-1], a_lo});
  assign ea2 = $signed({a_hi[W-1], a_hi});
  assign eb1 = $signed({b_lo[W-1], b_lo});
  assign eb2 = $signed({b_hi[W-1], b_hi});
  assign lt1 = $signed(a_lo) < $signed(b_lo);
  assign lt2 = $signed(a_hi) < $signed(b_hi);

  // Signs and magnitudes of all four bounds
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg[k] = raw[k][W-1];
      mag[k] = neg[k] ? (~raw[k] + 1'b1) : raw[k];
    end
  end

  // Divisor classification
  assign b1_pos = !neg[SLOT_B1] && (b_lo != '0);
  assign b2_pos = !neg[SLOT_B2] && (b_hi != '0);
  assign b_pos  = b1_pos && b2_pos;
  assign b_neg  = neg[SLOT_B1] && neg[SLOT_B2];

  // Pick dividend and divisor for the lower and upper quotient
  always_comb begin
    if (b_pos) begin
      xi[0] = SLOT_A1;
      yi[0] = neg[SLOT_A1] ? SLOT_B1 : SLOT_B2;
      xi[1] = SLOT_A2;
      yi[1] = neg[SLOT_A2] ? SLOT_B2 : SLOT_B1;
    end else begin
      xi[0] = SLOT_A2;
      yi[0] = neg[SLOT_A2] ? SLOT_B1 : SLOT_B2;
      xi[1] = SLOT_A1;
      yi[1] = neg[SLOT_A1] ? SLOT_B2 : SLOT_B1;
    end
    for (int l = 0; l < 2; l++) begin
      qs[l] = neg[xi[l]] ^ neg[yi[l]];
    end
  end

  // Status for divide requests
  always_comb begin
    st = ST_OK;
    if (opc == OP_DIV) begin
      if (!neg[SLOT_B2] && !b1_pos) begin
        st = ST_DIVZERO;
      end else if (!(b_pos || b_neg)) begin
        st = ST_INVALID;
      end
    end
  end

  // Bounds of the simple operations
  always_comb begin
    unique case (opc)
      OP_ADD: begin
        slo = ea1 + eb1;
        shi = ea2 + eb2;
      end
      OP_SUB: begin
        slo = ea1 - eb2;
        shi = ea2 - eb1;
      end
      OP_HULL: begin
        slo = lt1 ? ea1 : eb1;
        shi = lt2 ? eb2 : ea2;
      end
      OP_ISECT: begin
        slo = lt1 ? eb1 : ea1;
        shi = lt2 ? ea2 : eb2;
      end
      default: begin
        slo = '0;
        shi = '0;
      end
    endcase
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= in_v;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_op  <= opc;
      d_st  <= st;
      d_slo <= slo;
      d_shi <= shi;
      d_mag <= mag;
      d_sgn <= neg;
      d_qs  <= qs;
      for (int l = 0; l < 2; l++) begin
        d_num[l] <= mag[xi[l]];
        d_den[l] <= mag[yi[l]];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gia_div_chain.sv =====
// ----------------------------------------------------------------------------
// gia_div_chain
// Two-lane restoring divider, one quotient bit per register stage, followed
// by a sign stage. Side data rides along with each request.
// ----------------------------------------------------------------------------
`default_nettype none

module gia_div_chain #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [SW-1:0]          side_in,
  input  logic [1:0][W-1:0]      num,
  input  logic [1:0][W-1:0]      den,
  input  logic [1:0]             qs,
  output logic                   out_v,
  output logic [SW-1:0]          side_out,
  output logic [1:0][W+F:0]      quo
);
  localparam int N = W + F;

  logic          v    [1:N];
  logic [SW-1:0] sd   [1:N];
  logic [N-1:0]  nq   [0:1][1:N];
  logic [W-1:0]  rm   [0:1][1:N];
  logic [W-1:0]  dd   [0:1][1:N];
  logic          sg   [0:1][1:N];

  // One restoring step: shift in the next dividend bit, subtract when it fits
  function automatic logic [W+N-1:0] div_step(input logic [W-1:0] r,
                                             input logic [N-1:0] q,
                                             input logic [W-1:0] d);
    logic [W:0] r2;
    r2 = {r, q[N-1]};
    if (r2 >= {1'b0, d}) begin
      r2 = r2 - {1'b0, d};
      return {r2[W-1:0], q[N-2:0], 1'b1};
    end
    return {r2[W-1:0], q[N-2:0], 1'b0};
  endfunction

  // Advance the valid bits of the quotient stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= N; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[1] <= in_v;
      for (int i = 2; i <= N; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // One quotient bit per stage; the first stage loads the scaled dividend
  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= side_in;
      for (int l = 0; l < 2; l++) begin
        {rm[l][1], nq[l][1]} <= div_step('0, N'(num[l]) << F, den[l]);
        dd[l][1] <= den[l];
        sg[l][1] <= qs[l];
      end
      for (int i = 2; i <= N; i++) begin
        sd[i] <= sd[i-1];
        for (int l = 0; l < 2; l++) begin
          {rm[l][i], nq[l][i]} <= div_step(rm[l][i-1], nq[l][i-1], dd[l][i-1]);
          dd[l][i] <= dd[l][i-1];
          sg[l][i] <= sg[l][i-1];
        end
      end
    end
  end

  // Apply quotient signs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= sd[N];
      for (int l = 0; l < 2; l++) begin
        quo[l] <= sg[l][N] ? (~{1'b0, nq[l][N]} + 1'b1) : {1'b0, nq[l][N]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gia_mul.sv =====
// ----------------------------------------------------------------------------
// gia_mul
// Three-stage multiplier for the four end-point products: half-width partial
// products, partial sum with fraction truncation, then sign.
// ----------------------------------------------------------------------------
`default_nettype none

module gia_mul #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [SW-1:0]          side_in,
  input  logic [3:0][W-1:0]      mag,
  input  logic [3:0]             sgn,
  output logic                   out_v,
  output logic [SW-1:0]          side_out,
  output logic [3:0]             sgn_out,
  output logic [3:0][2*W-F:0]    prod
);
  import gia_pkg::*;

  localparam int HW = (W + 1) / 2;
  localparam int PM = 2 * W - F;

  logic [1:0]               av, sv;
  logic [SW-1:0]            a_sd, b_sd;
  logic [3:0]               a_sg, b_sg;
  logic [3:0]               a_ng, b_ng;
  logic [3:0][2*HW-1:0]     pll, plh, phl, phh;
  logic [3:0][PM-1:0]       pm;
  logic [3:0][1:0]          ai, bi;

  assign ai = {SLOT_A2, SLOT_A2, SLOT_A1, SLOT_A1};
  assign bi = {SLOT_B2, SLOT_B1, SLOT_B2, SLOT_B1};

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      av    <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      av    <= {av[0], in_v};
      out_v <= av[1];
    end
  end
  assign sv = av;

  // Stage A: partial products of the half-width digits
  always_ff @(posedge clk) begin
    if (en) begin
      a_sd <= side_in;
      a_sg <= sgn;
      for (int k = 0; k < 4; k++) begin
        logic [2*HW-1:0] x, y;
        x = (2*HW)'(mag[ai[k]]);
        y = (2*HW)'(mag[bi[k]]);
        pll[k]  <= (2*HW)'(x[HW-1:0] * y[HW-1:0]);
        plh[k]  <= (2*HW)'(x[HW-1:0] * y[2*HW-1:HW]);
        phl[k]  <= (2*HW)'(x[2*HW-1:HW] * y[HW-1:0]);
        phh[k]  <= (2*HW)'(x[2*HW-1:HW] * y[2*HW-1:HW]);
        a_ng[k] <= sgn[ai[k]] ^ sgn[bi[k]];
      end
    end
  end

  // Stage B: sum partials, drop fraction bits
  always_ff @(posedge clk) begin
    if (en && sv[0]) begin
      b_sd <= a_sd;
      b_sg <= a_sg;
      b_ng <= a_ng;
      for (int k = 0; k < 4; k++) begin
        logic [4*HW-1:0] full;
        full  = (4*HW)'(pll[k]) + ((4*HW)'(plh[k]) << HW) + ((4*HW)'(phl[k]) << HW)
              + ((4*HW)'(phh[k]) << (2*HW));
        pm[k] <= PM'(full[2*W-1:0] >> F);
      end
    end
  end

  // Stage C: apply product signs
  always_ff @(posedge clk) begin
    if (en && sv[1]) begin
      side_out <= b_sd;
      sgn_out  <= b_sg;
      for (int k = 0; k < 4; k++) begin
        prod[k] <= b_ng[k] ? (~{1'b0, pm[k]} + 1'b1) : {1'b0, pm[k]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gia_finish.sv =====
// ----------------------------------------------------------------------------
// gia_finish
// Result selection (multiply sign-class table, quotients, simple bounds),
// saturation, and the output register with a skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module gia_finish #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_v,
  input  gia_pkg::op_t           op,
  input  gia_pkg::status_t       st,
  input  logic [W:0]             slo,
  input  logic [W:0]             shi,
  input  logic [1:0][W+F:0]      quo,
  input  logic [3:0][2*W-F:0]    prod,
  input  logic [3:0]             sgn,
  input  logic                   res_stall,
  output logic                   en,
  output logic                   res_valid,
  output logic [W-1:0]           r_lo,
  output logic [W-1:0]           r_hi,
  output logic [1:0]             status
);
  import gia_pkg::*;

  localparam int PR  = 2 * W - F + 1;
  localparam int QW  = W + F + 1;
  localparam int RW0 = (PR > QW) ? PR : QW;
  localparam int RW  = (RW0 > W + 1) ? RW0 : W + 1;

  logic [1:0]      li, hi;
  logic            mzero;
  logic [RW-1:0]   lo_n, hi_n;
  logic            s_v;
  status_t         s_st;
  logic [RW-1:0]   s_lo, s_hi;
  logic [W-1:0]    lo_sat, hi_sat, sk_lo, sk_hi;
  logic            lo_ok, hi_ok;
  logic [1:0]      st_n, sk_st;
  logic            sk_v;
  logic            take;

  // Product slot signed compare
  function automatic logic plt(input logic [3:0][2*W-F:0] p, input logic [1:0] i,
                               input logic [1:0] j);
    plt = $signed(p[i]) < $signed(p[j]);
  endfunction

  // Multiply table over the bound sign classes
  always_comb begin
    li    = P11;
    hi    = P22;
    mzero = 1'b0;
    case (sgn[0 +: 4] == 4'b0 ? 4'd0 : {sgn[0], sgn[1], sgn[2], sgn[3]})
      4'd0:  begin li = P11; hi = P22; end
      4'd1:  begin li = P11; hi = P12; end
      4'd2:  begin li = P21; hi = P22; end
      4'd3:  begin li = P21; hi = P12; end
      4'd4:  begin li = P11; hi = P21; end
      4'd5:  begin
        li = plt(prod, P22, P11) ? P11 : P22;
        hi = plt(prod, P12, P21) ? P12 : P21;
      end
      4'd6:  mzero = 1'b1;
      4'd7:  begin li = P22; hi = P12; end
      4'd8:  begin li = P12; hi = P22; end
      4'd9:  mzero = 1'b1;
      4'd10: begin
        li = plt(prod, P21, P12) ? P21 : P12;
        hi = plt(prod, P11, P22) ? P22 : P11;
      end
      4'd11: begin li = P21; hi = P11; end
      4'd12: begin li = P12; hi = P21; end
      4'd13: begin li = P22; hi = P21; end
      4'd14: begin li = P12; hi = P11; end
      default: begin li = P22; hi = P11; end
    endcase
  end

  // Select the bounds for this op
  always_comb begin
    unique case (op) inside
      OP_ADD, OP_SUB, OP_HULL, OP_ISECT: begin
        lo_n = RW'($signed(slo));
        hi_n = RW'($signed(shi));
      end
      OP_MUL: begin
        lo_n = mzero ? '0 : RW'($signed(prod[li]));
        hi_n = mzero ? '0 : RW'($signed(prod[hi]));
      end
      OP_DIV: begin
        lo_n = (st == ST_OK) ? RW'($signed(quo[0])) : '0;
        hi_n = (st == ST_OK) ? RW'($signed(quo[1])) : '0;
      end
      default: begin
        lo_n = '0;
        hi_n = '0;
      end
    endcase
  end

  // Select stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (en) begin
      s_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_lo <= lo_n;
      s_hi <= hi_n;
      s_st <= st;
    end
  end

  // Saturate to the bound width
  assign lo_ok  = s_lo[RW-1:W-1] == {(RW-W+1){s_lo[RW-1]}};
  assign hi_ok  = s_hi[RW-1:W-1] == {(RW-W+1){s_hi[RW-1]}};
  assign lo_sat = lo_ok ? s_lo[W-1:0] : {s_lo[RW-1], {(W-1){!s_lo[RW-1]}}};
  assign hi_sat = hi_ok ? s_hi[W-1:0] : {s_hi[RW-1], {(W-1){!s_hi[RW-1]}}};
  assign st_n   = (s_st != ST_OK) ? s_st : ((lo_ok && hi_ok) ? ST_OK : ST_OVF);

  // Output register with a skid entry; hold the pipeline while the skid is full
  assign en   = !sk_v;
  assign take = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (take) begin
      res_valid <= sk_v || s_v;
      sk_v      <= 1'b0;
    end else if (en && s_v) begin
      sk_v      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r_lo   <= sk_v ? sk_lo : lo_sat;
      r_hi   <= sk_v ? sk_hi : hi_sat;
      status <= sk_v ? sk_st : st_n;
    end else if (en && s_v) begin
      sk_lo <= lo_sat;
      sk_hi <= hi_sat;
      sk_st <= st_n;
    end
  end

endmodule

`default_nettype wire
